// ===== hdl/sla_pkg.sv =====
// Shared types and constants of the status LED animator.
// Depends on nothing; every other file in hdl uses it.
package sla_pkg;

  localparam int unsigned ReqTypeW = 2;
  localparam int unsigned StatusW  = 3;
  localparam int unsigned ChanW    = 8;
  localparam int unsigned RgbW     = 3 * ChanW;
  localparam int unsigned PeriodW  = 16;
  localparam int unsigned CfgIdxW  = 3;
  localparam int unsigned CfgDataW = RgbW;

  // Request types.
  localparam logic [ReqTypeW-1:0] ReqTick      = 2'd0;
  localparam logic [ReqTypeW-1:0] ReqSetStatus = 2'd1;
  localparam logic [ReqTypeW-1:0] ReqSetColor  = 2'd2;

  // Status modes, also the state codes of the animator.
  localparam logic [StatusW-1:0] ModeIdle         = 3'd0;
  localparam logic [StatusW-1:0] ModeBusy         = 3'd1;
  localparam logic [StatusW-1:0] ModeSuccess      = 3'd2;
  localparam logic [StatusW-1:0] ModeError        = 3'd3;
  localparam logic [StatusW-1:0] ModeConnected    = 3'd4;
  localparam logic [StatusW-1:0] ModeDisconnected = 3'd5;

  // Configuration register indexes.
  localparam logic [CfgIdxW-1:0] CfgBreathPeriod  = 3'd0;
  localparam logic [CfgIdxW-1:0] CfgFlashPeriod   = 3'd1;
  localparam logic [CfgIdxW-1:0] CfgIdleColor     = 3'd2;
  localparam logic [CfgIdxW-1:0] CfgBusyColor     = 3'd3;
  localparam logic [CfgIdxW-1:0] CfgSuccessColor  = 3'd4;
  localparam logic [CfgIdxW-1:0] CfgErrorColor    = 3'd5;
  localparam logic [CfgIdxW-1:0] CfgConnectedColor = 3'd6;

  typedef struct packed {
    logic [PeriodW-1:0] breath_period;
    logic [PeriodW-1:0] flash_period;
    logic [RgbW-1:0]    idle_color;
    logic [RgbW-1:0]    busy_color;
    logic [RgbW-1:0]    success_color;
    logic [RgbW-1:0]    error_color;
    logic [RgbW-1:0]    connected_color;
  } sla_cfg_t;

  typedef struct packed {
    logic [ReqTypeW-1:0] req_type;
    logic [StatusW-1:0]  new_status;
    logic [ChanW-1:0]    red;
    logic [ChanW-1:0]    green;
    logic [ChanW-1:0]    blue;
  } sla_item_t;

  typedef struct packed {
    logic            emit;
    logic [RgbW-1:0] rgb;
  } sla_res_t;

endpackage

// ===== hdl/sla_req_if.sv =====
// Request channel of the status LED animator: valid/ready plus one request word.
// Depends on sla_pkg for the field widths.
interface sla_req_if;
  logic                          valid;
  logic                          ready;
  logic [sla_pkg::ReqTypeW-1:0]  req_type;
  logic [sla_pkg::StatusW-1:0]   new_status;
  logic [sla_pkg::ChanW-1:0]     red_in;
  logic [sla_pkg::ChanW-1:0]     green_in;
  logic [sla_pkg::ChanW-1:0]     blue_in;

  modport source (output valid, req_type, new_status, red_in, green_in, blue_in,
                  input ready);
  modport sink (input valid, req_type, new_status, red_in, green_in, blue_in,
                output ready);
endinterface

// ===== hdl/sla_rsp_if.sv =====
// Result channel of the status LED animator: valid/ready plus one color word.
// Depends on sla_pkg for the field widths.
interface sla_rsp_if;
  logic                      valid;
  logic                      ready;
  logic [sla_pkg::ChanW-1:0] red_out;
  logic [sla_pkg::ChanW-1:0] green_out;
  logic [sla_pkg::ChanW-1:0] blue_out;

  modport source (output valid, red_out, green_out, blue_out, input ready);
  modport sink (input valid, red_out, green_out, blue_out, output ready);
endinterface

// ===== hdl/status_led_animator_top.sv =====
// Top level of the status LED animator: input register, engine, result register.
// Depends on sla_pkg, sla_req_if, sla_rsp_if, sla_cfg_regs and sla_engine.

// Each request word is registered on acceptance and handled by the engine once the
// result side can advance, which puts its color word in the result register. One
// word is accepted every cycle unless the result side stalls, a rate set by the
// single input and result registers around the registered state update. The result
// register holds a finished word while the next request is taken; only when the
// result is held and a further word waits in the input register does the request
// side stall. Ticks in static modes, repeated statuses, unknown codes and the end
// of a flash sequence produce no word. Configuration writes take effect at once
// and are meant to be made while no request is in flight.
module status_led_animator_top (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          cfg_we_i,
  input  logic [sla_pkg::CfgIdxW-1:0]   cfg_idx_i,
  input  logic [sla_pkg::CfgDataW-1:0]  cfg_wdata_i,
  sla_req_if.sink                       req_i,
  sla_rsp_if.source                     rsp_o
);
  import sla_pkg::*;

  sla_cfg_t  cfg;
  sla_item_t item_q;
  sla_res_t  res;
  logic      in_valid_q;
  logic      out_valid_q;
  logic [RgbW-1:0] out_rgb_q;
  logic      adv;
  logic      proc;

  assign adv         = !out_valid_q || rsp_o.ready;
  assign proc        = in_valid_q && adv;
  assign req_i.ready = !in_valid_q || adv;

  sla_cfg_regs u_cfg (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .cfg_idx_i   (cfg_idx_i),
    .cfg_wdata_i (cfg_wdata_i),
    .cfg_o       (cfg)
  );

  sla_engine u_engine (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .proc_i (proc),
    .item_i (item_q),
    .cfg_i  (cfg),
    .res_o  (res)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q  <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      if (req_i.valid && req_i.ready) begin
        in_valid_q <= 1'b1;
      end else if (proc) begin
        in_valid_q <= 1'b0;
      end
      if (adv) begin
        out_valid_q <= proc && res.emit;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (req_i.valid && req_i.ready) begin
      item_q.req_type   <= req_i.req_type;
      item_q.new_status <= req_i.new_status;
      item_q.red        <= req_i.red_in;
      item_q.green      <= req_i.green_in;
      item_q.blue       <= req_i.blue_in;
    end
    if (proc && res.emit) begin
      out_rgb_q <= res.rgb;
    end
  end

  assign rsp_o.valid     = out_valid_q;
  assign rsp_o.red_out   = out_rgb_q[23:16];
  assign rsp_o.green_out = out_rgb_q[15:8];
  assign rsp_o.blue_out  = out_rgb_q[7:0];

endmodule

// ===== hdl/sla_cfg_regs.sv =====
// Configuration register file of the status LED animator.
// Depends on sla_pkg for register indexes and the config struct.
module sla_cfg_regs (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          cfg_we_i,
  input  logic [sla_pkg::CfgIdxW-1:0]   cfg_idx_i,
  input  logic [sla_pkg::CfgDataW-1:0]  cfg_wdata_i,
  output sla_pkg::sla_cfg_t             cfg_o
);
  import sla_pkg::*;

  sla_cfg_t cfg_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.breath_period   <= 16'd50;
      cfg_q.flash_period    <= 16'd150;
      cfg_q.idle_color      <= 24'h00FFFF;
      cfg_q.busy_color      <= 24'hFFFF00;
      cfg_q.success_color   <= 24'h00FF00;
      cfg_q.error_color     <= 24'hFF0000;
      cfg_q.connected_color <= 24'h0000FF;
    end else if (cfg_we_i) begin
      unique case (cfg_idx_i)
        CfgBreathPeriod:   cfg_q.breath_period   <= cfg_wdata_i[PeriodW-1:0];
        CfgFlashPeriod:    cfg_q.flash_period    <= cfg_wdata_i[PeriodW-1:0];
        CfgIdleColor:      cfg_q.idle_color      <= cfg_wdata_i;
        CfgBusyColor:      cfg_q.busy_color      <= cfg_wdata_i;
        CfgSuccessColor:   cfg_q.success_color   <= cfg_wdata_i;
        CfgErrorColor:     cfg_q.error_color     <= cfg_wdata_i;
        CfgConnectedColor: cfg_q.connected_color <= cfg_wdata_i;
        default: ;
      endcase
    end
  end

  assign cfg_o = cfg_q;

endmodule

// ===== hdl/sla_engine.sv =====
// Animation state and next-state logic: mode, target color, millisecond count,
// breathing step and flash phase. Depends on sla_pkg.
module sla_engine (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               proc_i,
  input  sla_pkg::sla_item_t item_i,
  input  sla_pkg::sla_cfg_t  cfg_i,
  output sla_pkg::sla_res_t  res_o
);
  import sla_pkg::*;

  logic [StatusW-1:0] mode_q, mode_d;
  logic [RgbW-1:0]    target_q, target_d;
  logic [PeriodW-1:0] elapsed_q, elapsed_d, elapsed_inc;
  logic [5:0]         step_q, step_d, step_inc;
  logic [1:0]         flashes_q, flashes_d;
  logic               flash_on_q, flash_on_d;
  logic [ChanW-1:0]   bright;

  // Exact floor(c * b / 255) for products below 65535.
  function automatic logic [ChanW-1:0] scale(input logic [ChanW-1:0] c,
                                            input logic [ChanW-1:0] b);
    logic [15:0] p;
    logic [15:0] s;
    p = c * b;
    s = p + 16'd1 + {8'd0, p[15:8]};
    return s[15:8];
  endfunction

  always_comb begin
    mode_d      = mode_q;
    target_d    = target_q;
    elapsed_d   = elapsed_q;
    step_d      = step_q;
    flashes_d   = flashes_q;
    flash_on_d  = flash_on_q;
    res_o.emit  = 1'b0;
    res_o.rgb   = target_q;

    elapsed_inc = (elapsed_q == '1) ? elapsed_q : elapsed_q + 16'd1;
    step_inc    = step_q + 6'd1;
    // Triangle ramp: rising for the lower half, falling for the upper half.
    bright      = step_inc[5] ? {~step_inc[4:0], 3'b000} : {step_inc[4:0], 3'b000};

    if (proc_i) begin
      unique case (item_i.req_type)
        ReqTick: begin
          elapsed_d = elapsed_inc;
          if (mode_q == ModeIdle) begin
            if (elapsed_inc >= cfg_i.breath_period) begin
              elapsed_d  = '0;
              step_d     = step_inc;
              res_o.emit = 1'b1;
              res_o.rgb  = {scale(target_q[23:16], bright),
                            scale(target_q[15:8], bright),
                            scale(target_q[7:0], bright)};
            end
          end else if (mode_q == ModeSuccess || mode_q == ModeError) begin
            if (elapsed_inc >= cfg_i.flash_period) begin
              elapsed_d = '0;
              if (flashes_q == 2'd0) begin
                // All flashes shown: fall back to idle without a word.
                mode_d     = ModeIdle;
                step_d     = '0;
                flash_on_d = 1'b1;
                target_d   = cfg_i.idle_color;
              end else begin
                res_o.emit = 1'b1;
                if (!flash_on_q) begin
                  res_o.rgb = '0;
                  flashes_d = flashes_q - 2'd1;
                end
                flash_on_d = ~flash_on_q;
              end
            end
          end
        end
        ReqSetStatus: begin
          if (item_i.new_status <= ModeDisconnected && item_i.new_status != mode_q) begin
            mode_d     = item_i.new_status;
            step_d     = '0;
            flashes_d  = 2'd0;
            flash_on_d = 1'b1;
            elapsed_d  = '0;
            unique case (item_i.new_status)
              ModeIdle:      target_d = cfg_i.idle_color;
              ModeBusy: begin
                target_d   = cfg_i.busy_color;
                res_o.emit = 1'b1;
              end
              ModeSuccess: begin
                target_d  = cfg_i.success_color;
                flashes_d = 2'd2;
              end
              ModeError: begin
                target_d  = cfg_i.error_color;
                flashes_d = 2'd3;
              end
              ModeConnected: begin
                target_d   = cfg_i.connected_color;
                res_o.emit = 1'b1;
              end
              default: begin
                target_d   = '0;
                res_o.emit = 1'b1;
              end
            endcase
            res_o.rgb = target_d;
          end
        end
        ReqSetColor: begin
          target_d   = {item_i.red, item_i.green, item_i.blue};
          res_o.emit = 1'b1;
          res_o.rgb  = target_d;
        end
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mode_q     <= ModeDisconnected;
      target_q   <= '0;
      elapsed_q  <= '0;
      step_q     <= '0;
      flashes_q  <= '0;
      flash_on_q <= 1'b0;
    end else begin
      mode_q     <= mode_d;
      target_q   <= target_d;
      elapsed_q  <= elapsed_d;
      step_q     <= step_d;
      flashes_q  <= flashes_d;
      flash_on_q <= flash_on_d;
    end
  end

endmodule

// ===== test/sla_led_checker.sv =====
// Checker for the status LED animator: watches both word channels and the config port,
// predicts every color word and compares it. Depends on sla_pkg, sla_req_if, sla_rsp_if.
module sla_led_checker
  import sla_pkg::*;
(
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                cfg_we_i,
  input  logic [CfgIdxW-1:0]  cfg_idx_i,
  input  logic [CfgDataW-1:0] cfg_wdata_i,
  sla_req_if                  req,
  sla_rsp_if                  rsp,
  output int unsigned         fail_count_o,
  output int unsigned         pending_o,
  output int unsigned         words_checked_o
);
  timeunit 1ns;
  timeprecision 1ps;

  sla_cfg_t            cfg_shadow;
  logic [StatusW-1:0]  led_mode;
  logic [RgbW-1:0]     target_rgb;
  logic [PeriodW-1:0]  elapsed_ms;
  logic [5:0]          breath_step;
  logic [1:0]          flashes_left;
  logic                flash_on;

  logic [RgbW-1:0]     expected_color_q[$];
  sla_item_t           seen_word;
  logic                will_show;
  logic [RgbW-1:0]     shown_rgb;
  logic [RgbW-1:0]     want_rgb;

  function automatic logic [ChanW-1:0] dim(input logic [ChanW-1:0] c, input int unsigned level);
    return ChanW'((int'(c) * level) / 255);
  endfunction

  // Loads a new mode; returns whether that mode shows its color right away.
  function automatic logic enter_mode(input logic [StatusW-1:0] m);
    logic shows;
    shows        = 1'b0;
    led_mode     = m;
    breath_step  = '0;
    flashes_left = '0;
    flash_on     = 1'b1;
    elapsed_ms   = '0;
    case (m)
      ModeIdle:      target_rgb = cfg_shadow.idle_color;
      ModeBusy: begin
        target_rgb = cfg_shadow.busy_color;
        shows      = 1'b1;
      end
      ModeSuccess: begin
        target_rgb   = cfg_shadow.success_color;
        flashes_left = 2'd2;
      end
      ModeError: begin
        target_rgb   = cfg_shadow.error_color;
        flashes_left = 2'd3;
      end
      ModeConnected: begin
        target_rgb = cfg_shadow.connected_color;
        shows      = 1'b1;
      end
      default: begin
        target_rgb = '0;
        shows      = 1'b1;
      end
    endcase
    return shows;
  endfunction

  function automatic void predict_color(input sla_item_t w, output logic shows,
                                        output logic [RgbW-1:0] rgb);
    int unsigned level;
    shows = 1'b0;
    rgb   = '0;
    case (w.req_type)
      ReqTick: begin
        if (elapsed_ms != '1) elapsed_ms = elapsed_ms + 1'b1;
        if (led_mode == ModeIdle) begin
          if (elapsed_ms >= cfg_shadow.breath_period) begin
            elapsed_ms  = '0;
            breath_step = breath_step + 1'b1;
            // Triangle ramp: up over the first half of the 64 steps, down over the second.
            level = (breath_step < 6'd32) ? breath_step * 8 : (63 - breath_step) * 8;
            rgb   = {dim(target_rgb[23:16], level), dim(target_rgb[15:8], level),
                     dim(target_rgb[7:0], level)};
            shows = 1'b1;
          end
        end else if (led_mode == ModeSuccess || led_mode == ModeError) begin
          if (elapsed_ms >= cfg_shadow.flash_period) begin
            elapsed_ms = '0;
            if (flashes_left == '0) begin
              // The sequence is over: drop back to idle without a word.
              void'(enter_mode(ModeIdle));
            end else begin
              if (flash_on) begin
                rgb = target_rgb;
              end else begin
                flashes_left = flashes_left - 1'b1;
              end
              flash_on = ~flash_on;
              shows    = 1'b1;
            end
          end
        end
      end
      ReqSetStatus: begin
        if (w.new_status <= ModeDisconnected && w.new_status != led_mode) begin
          shows = enter_mode(w.new_status);
          rgb   = target_rgb;
        end
      end
      ReqSetColor: begin
        target_rgb = {w.red, w.green, w.blue};
        rgb        = target_rgb;
        shows      = 1'b1;
      end
      default: ;
    endcase
  endfunction

  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_shadow.breath_period   = 16'd50;
      cfg_shadow.flash_period    = 16'd150;
      cfg_shadow.idle_color      = 24'h00FFFF;
      cfg_shadow.busy_color      = 24'hFFFF00;
      cfg_shadow.success_color   = 24'h00FF00;
      cfg_shadow.error_color     = 24'hFF0000;
      cfg_shadow.connected_color = 24'h0000FF;
      led_mode        = ModeDisconnected;
      target_rgb      = '0;
      elapsed_ms      = '0;
      breath_step     = '0;
      flashes_left    = '0;
      flash_on        = 1'b0;
      expected_color_q.delete();
      pending_o       = 0;
      words_checked_o = 0;
      fail_count_o    = 0;
    end else begin
      if (cfg_we_i) begin
        case (cfg_idx_i)
          CfgBreathPeriod:   cfg_shadow.breath_period   = cfg_wdata_i[PeriodW-1:0];
          CfgFlashPeriod:    cfg_shadow.flash_period    = cfg_wdata_i[PeriodW-1:0];
          CfgIdleColor:      cfg_shadow.idle_color      = cfg_wdata_i;
          CfgBusyColor:      cfg_shadow.busy_color      = cfg_wdata_i;
          CfgSuccessColor:   cfg_shadow.success_color   = cfg_wdata_i;
          CfgErrorColor:     cfg_shadow.error_color     = cfg_wdata_i;
          CfgConnectedColor: cfg_shadow.connected_color = cfg_wdata_i;
          default: ;
        endcase
      end
      if (rsp.valid && rsp.ready) begin
        if (expected_color_q.size() == 0) begin
          $error("unexpected color word %02h %02h %02h", rsp.red_out, rsp.green_out,
                 rsp.blue_out);
          fail_count_o++;
        end else begin
          want_rgb = expected_color_q.pop_front();
          words_checked_o++;
          if (rsp.red_out !== want_rgb[23:16]) begin
            $error("red_out: expected %0d, got %0d", want_rgb[23:16], rsp.red_out);
            fail_count_o++;
          end
          if (rsp.green_out !== want_rgb[15:8]) begin
            $error("green_out: expected %0d, got %0d", want_rgb[15:8], rsp.green_out);
            fail_count_o++;
          end
          if (rsp.blue_out !== want_rgb[7:0]) begin
            $error("blue_out: expected %0d, got %0d", want_rgb[7:0], rsp.blue_out);
            fail_count_o++;
          end
        end
      end
      if (req.valid && req.ready) begin
        seen_word = '{req_type: req.req_type, new_status: req.new_status, red: req.red_in,
                      green: req.green_in, blue: req.blue_in};
        predict_color(seen_word, will_show, shown_rgb);
        if (will_show) expected_color_q.push_back(shown_rgb);
      end
      pending_o = expected_color_q.size();
    end
  end

endmodule

// ===== test/status_led_animator_top_tb.sv =====
// Testbench top for the status LED animator: clock, reset, stimulus, back-pressure and verdict.
// Depends on sla_pkg, the two channel interfaces, the RTL top and sla_led_checker.
module status_led_animator_top_tb;
  import sla_pkg::*;
  timeunit 1ns;
  timeprecision 1ps;

  localparam logic [ReqTypeW-1:0] ReqUnused    = 2'd3;
  localparam logic [StatusW-1:0]  StatusUnused = 3'd6;
  localparam int unsigned         QuietLimit   = 4000;
  localparam int unsigned         SettleCycles = 6;

  logic                clk_i = 1'b0;
  logic                rst_ni;
  logic                cfg_we_i;
  logic [CfgIdxW-1:0]  cfg_idx_i;
  logic [CfgDataW-1:0] cfg_wdata_i;

  sla_req_if req_ch ();
  sla_rsp_if rsp_ch ();

  int unsigned fail_count;
  int unsigned pending;
  int unsigned words_checked;
  int unsigned words_sent;
  int unsigned configs_applied;
  int unsigned send_idle_pct;
  int unsigned stall_pct;
  int unsigned hold_len;
  int unsigned hold_seq;
  int unsigned hold_seen;
  int unsigned hold_left;
  int unsigned quiet_cycles;

  status_led_animator_top u_dut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .cfg_idx_i   (cfg_idx_i),
    .cfg_wdata_i (cfg_wdata_i),
    .req_i       (req_ch),
    .rsp_o       (rsp_ch)
  );

  sla_led_checker u_checker (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .cfg_we_i        (cfg_we_i),
    .cfg_idx_i       (cfg_idx_i),
    .cfg_wdata_i     (cfg_wdata_i),
    .req             (req_ch),
    .rsp             (rsp_ch),
    .fail_count_o    (fail_count),
    .pending_o       (pending),
    .words_checked_o (words_checked)
  );

  always #5 clk_i = ~clk_i;

  // Result side: random stalls, or a long hold-off when the stimulus asks for one.
  always @(posedge clk_i) begin
    if (hold_seq != hold_seen) begin
      hold_seen = hold_seq;
      hold_left = hold_len;
    end
    if (hold_left != 0) begin
      hold_left--;
      rsp_ch.ready <= 1'b0;
    end else begin
      rsp_ch.ready <= rst_ni && ($urandom_range(99) >= stall_pct);
    end
  end

  always @(posedge clk_i) begin
    if (rst_ni === 1'b1) begin
      if ((req_ch.valid && req_ch.ready) || (rsp_ch.valid && rsp_ch.ready)) begin
        quiet_cycles = 0;
      end else begin
        quiet_cycles++;
        if (quiet_cycles >= QuietLimit) begin
          $display("status_led_animator_top_tb NOT OK");
          $finish;
        end
      end
    end
  end

  task automatic send_word(input logic [ReqTypeW-1:0] rt, input logic [StatusW-1:0] st,
                           input logic [RgbW-1:0] rgb);
    while ($urandom_range(99) < send_idle_pct) begin
      req_ch.valid <= 1'b0;
      @(posedge clk_i);
    end
    req_ch.valid      <= 1'b1;
    req_ch.req_type   <= rt;
    req_ch.new_status <= st;
    req_ch.red_in     <= rgb[23:16];
    req_ch.green_in   <= rgb[15:8];
    req_ch.blue_in    <= rgb[7:0];
    do @(posedge clk_i); while (!req_ch.ready);
    words_sent++;
  endtask

  task automatic send_tick();
    send_word(ReqTick, StatusW'($urandom_range(7)), RgbW'($urandom()));
  endtask

  // Stop offering words, wait for every predicted color, then let in-flight silent words
  // drain out of the pipeline.
  task automatic drain();
    req_ch.valid <= 1'b0;
    @(posedge clk_i);
    while (pending != 0) @(posedge clk_i);
    repeat (SettleCycles) @(posedge clk_i);
  endtask

  task automatic write_config(input logic [PeriodW-1:0] breath, input logic [PeriodW-1:0] flash,
                              input logic [RgbW-1:0] idle_c, input logic [RgbW-1:0] busy_c,
                              input logic [RgbW-1:0] success_c, input logic [RgbW-1:0] error_c,
                              input logic [RgbW-1:0] connected_c);
    logic [CfgIdxW-1:0]  reg_idx[7];
    logic [CfgDataW-1:0] reg_val[7];
    reg_idx = '{CfgBreathPeriod, CfgFlashPeriod, CfgIdleColor, CfgBusyColor,
                CfgSuccessColor, CfgErrorColor, CfgConnectedColor};
    reg_val = '{CfgDataW'(breath), CfgDataW'(flash), idle_c, busy_c, success_c, error_c,
                connected_c};
    cfg_we_i <= 1'b1;
    for (int i = 0; i < 7; i++) begin
      cfg_idx_i   <= reg_idx[i];
      cfg_wdata_i <= reg_val[i];
      @(posedge clk_i);
    end
    cfg_we_i <= 1'b0;
    configs_applied++;
  endtask

  task automatic random_config(input int unsigned max_period);
    write_config(PeriodW'($urandom_range(1, max_period)), PeriodW'($urandom_range(1, max_period)),
                 RgbW'($urandom()), RgbW'($urandom()), RgbW'($urandom()), RgbW'($urandom()),
                 RgbW'($urandom()));
  endtask

  // Mostly ticks so that breathing and flash sequences run to completion, with status
  // changes, color changes and a little junk mixed in.
  task automatic random_words(input int unsigned count);
    int unsigned pick;
    repeat (count) begin
      pick = $urandom_range(99);
      if (pick < 66) begin
        send_tick();
      end else if (pick < 80) begin
        send_word(ReqSetStatus, StatusW'($urandom_range(0, 5)), RgbW'($urandom()));
      end else if (pick < 83) begin
        send_word(ReqSetStatus, StatusW'($urandom_range(6, 7)), RgbW'($urandom()));
      end else if (pick < 96) begin
        send_word(ReqSetColor, StatusW'($urandom_range(7)), RgbW'($urandom()));
      end else begin
        send_word(ReqUnused, StatusW'($urandom_range(7)), RgbW'($urandom()));
      end
    end
  endtask

  initial begin
    int unsigned idle_plan[4];
    int unsigned stall_plan[4];
    idle_plan  = '{0, 78, 0, 14};
    stall_plan = '{0, 0, 78, 14};
    rst_ni            <= 1'b0;
    cfg_we_i          <= 1'b0;
    cfg_idx_i         <= CfgBreathPeriod;
    cfg_wdata_i       <= '0;
    req_ch.valid      <= 1'b0;
    req_ch.req_type   <= ReqTick;
    req_ch.new_status <= ModeIdle;
    req_ch.red_in     <= '0;
    req_ch.green_in   <= '0;
    req_ch.blue_in    <= '0;
    send_idle_pct = 0;
    stall_pct     = 0;
    hold_len      = 0;
    hold_seq      = 0;
    words_sent    = 0;
    configs_applied = 0;
    repeat (9) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Directed, reset settings: repeated and unknown statuses, unknown request, color extremes.
    send_word(ReqSetStatus, ModeDisconnected, '0);
    send_word(ReqSetStatus, StatusUnused, '0);
    send_word(ReqUnused, ModeBusy, '1);
    send_word(ReqSetColor, ModeIdle, 24'h000000);
    send_word(ReqSetColor, ModeIdle, 24'hFFFFFF);
    send_word(ReqSetStatus, ModeBusy, '0);
    send_word(ReqSetStatus, ModeConnected, '0);
    send_word(ReqSetStatus, ModeDisconnected, '0);
    drain();

    // Zero periods fire on every tick; full-scale colors show the ramp exactly.
    write_config('0, '0, 24'hFFFFFF, 24'h000000, 24'hFFFFFF, 24'h5A5AA5, 24'h000000);
    send_word(ReqSetStatus, ModeIdle, '0);
    repeat (2) send_word(ReqTick, ModeIdle, '0);
    send_word(ReqSetStatus, ModeSuccess, '0);
    // Two on/off pairs, then the silent return to idle, then one breath.
    repeat (6) send_word(ReqTick, ModeIdle, '0);
    send_word(ReqSetStatus, ModeError, '0);
    repeat (7) send_word(ReqTick, ModeIdle, '0);
    drain();

    for (int p = 0; p < 4; p++) begin
      send_idle_pct = idle_plan[p];
      stall_pct     = stall_plan[p];
      if (p == 0) begin
        write_config(16'd1, 16'd1, RgbW'($urandom()), RgbW'($urandom()), RgbW'($urandom()),
                     RgbW'($urandom()), RgbW'($urandom()));
      end else begin
        random_config(5);
      end
      random_words(215);
      drain();
    end

    // Hold the result side while words keep coming, so the pipeline fills and stalls.
    send_idle_pct = 0;
    stall_pct     = 14;
    random_config(4);
    hold_len = 300;
    hold_seq++;
    repeat (12) send_word(ReqSetColor, ModeIdle, RgbW'($urandom()));
    random_words(30);
    drain();

    // Largest periods: a short idle run in which no breathing step is due yet.
    stall_pct = 0;
    write_config('1, '1, RgbW'($urandom()), RgbW'($urandom()), RgbW'($urandom()),
                 RgbW'($urandom()), RgbW'($urandom()));
    send_word(ReqSetStatus, ModeBusy, '0);
    send_word(ReqSetStatus, ModeIdle, '0);
    repeat (20) send_word(ReqTick, ModeIdle, '0);
    drain();

    $display("Drove %0d request words and checked %0d color words under %0d settings,",
             words_sent, words_checked, configs_applied);
    $display("from zero to full-scale periods, with idle gaps, stalls and a long output hold.");
    if (fail_count == 0 && pending == 0) begin
      $display("status_led_animator_top_tb OK");
    end else begin
      $display("status_led_animator_top_tb NOT OK");
    end
    $finish;
  end

endmodule
